FILE: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include guarded
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FBCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbcc check failed");

// next-cycle implication, disabled during reset
`define FBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbcc check failed");

`endif

FILE: src/fbcc_pkg.sv
// shared constants, types and helpers of the fifo block cache controller
// no dependencies
`default_nettype none

package fbcc_pkg;

    localparam int ENTRIES   = 4;
    localparam int KEY_BITS  = 20;
    localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_BITS = $clog2(ENTRIES + 1);
    localparam int SUM_BITS  = SLOT_BITS + 1;
    localparam int CMD_BITS  = 2;

    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_FLUSH
    } fbcc_state_t;

    typedef struct packed {
        logic capture;
        logic access_go;
        logic flush_step;
        logic flush_emit;
        logic flush_clear;
    } fbcc_cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_done;
        logic cur_dirty;
    } fbcc_stat_t;

    // ring position: sum is always below twice the entry count
    function automatic logic [SLOT_BITS-1:0] ring_wrap(input logic [SUM_BITS-1:0] sum);
        logic [SUM_BITS-1:0] adj;
        begin
            adj = (sum >= SUM_BITS'(ENTRIES)) ? sum - SUM_BITS'(ENTRIES) : sum;
            ring_wrap = adj[SLOT_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/fbcc_if.sv
// request and result channel interfaces with valid/ready handshake
// depends on fbcc_pkg
`default_nettype none

interface fbcc_req_if import fbcc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_BITS-1:0] command;
    logic [KEY_BITS-1:0] block_key;

    modport source (output valid, output command, output block_key, input ready);
    modport sink (input valid, input command, input block_key, output ready);
endinterface

interface fbcc_rsp_if import fbcc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 fill_needed;
    logic                 writeback_needed;
    logic [KEY_BITS-1:0]  writeback_key;
    logic                 last;

    modport source (output valid, output hit, output slot, output fill_needed,
                    output writeback_needed, output writeback_key, output last,
                    input ready);
    modport sink (input valid, input hit, input slot, input fill_needed,
                  input writeback_needed, input writeback_key, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: src/fifo_block_cache_controller.sv
// fifo block cache controller: tag and replacement manager, top level
// access: the result is registered from the access state once the result register is free
// requests: no new request is taken until the result of the last one is registered
// flush: one scan position per cycle while no dirty entry waits on a busy result register
// reset: valid and dirty bits, oldest pointer and fill count clear at once
// depends on fbcc_pkg, fbcc_if, fbcc_ctrl, fbcc_dp
`default_nettype none

module fifo_block_cache_controller import fbcc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fbcc_req_if.sink   req,
    fbcc_rsp_if.source rsp
);

    fbcc_cmd_t  cmd;
    fbcc_stat_t stat;

    fbcc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    fbcc_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .in_command           (req.command),
        .in_block_key         (req.block_key),
        .out_valid            (rsp.valid),
        .out_ready            (rsp.ready),
        .out_hit              (rsp.hit),
        .out_slot             (rsp.slot),
        .out_fill_needed      (rsp.fill_needed),
        .out_writeback_needed (rsp.writeback_needed),
        .out_writeback_key    (rsp.writeback_key),
        .out_last             (rsp.last)
    );

endmodule

`default_nettype wire

FILE: src/fbcc_ctrl.sv
// controller state machine: request intake, access update and flush scan
// depends on fbcc_pkg
`default_nettype none

module fbcc_ctrl import fbcc_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [CMD_BITS-1:0] in_command,
    output logic                     in_ready,
    input  wire fbcc_stat_t          stat,
    output fbcc_cmd_t                cmd
);

    fbcc_state_t state_reg;
    fbcc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_command) inside
                        CMD_READ, CMD_WRITE: state_next = ST_ACCESS;
                        CMD_FLUSH:           state_next = ST_FLUSH;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACCESS:
            begin
                if (stat.out_free)
                begin
                    cmd.access_go = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (stat.scan_done)
                begin
                    cmd.flush_clear = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (!stat.cur_dirty)
                begin
                    cmd.flush_step = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.flush_step = 1'b1;
                    cmd.flush_emit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/fbcc_dp.sv
// datapath: tag store, fifo pointers, flush scan and result register
// depends on fbcc_pkg
`default_nettype none

module fbcc_dp import fbcc_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fbcc_cmd_t            cmd,
    output fbcc_stat_t                stat,
    input  wire logic [CMD_BITS-1:0]  in_command,
    input  wire logic [KEY_BITS-1:0]  in_block_key,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_hit,
    output logic [SLOT_BITS-1:0]      out_slot,
    output logic                      out_fill_needed,
    output logic                      out_writeback_needed,
    output logic [KEY_BITS-1:0]       out_writeback_key,
    output logic                      out_last
);

    logic [KEY_BITS-1:0]  entry_key_reg [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [ENTRIES-1:0]   dirty_reg, dirty_next;
    logic [SLOT_BITS-1:0] oldest_reg, oldest_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [FILL_BITS-1:0] idx_reg, idx_next;
    logic [FILL_BITS-1:0] remain_reg, remain_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic                 write_reg;
    logic                 out_valid_reg, out_valid_next;

    logic                 hit_any;
    logic [SLOT_BITS-1:0] hit_slot;
    logic                 full;
    logic [SLOT_BITS-1:0] alloc_slot;
    logic [SLOT_BITS-1:0] scan_slot;
    logic [FILL_BITS-1:0] dirty_count;
    logic                 access_wb;
    logic                 load_out;
    logic                 wr_entry;

    // associative lookup
    always_comb
    begin
        hit_any  = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && entry_key_reg[i] == key_reg)
            begin
                hit_any  = 1'b1;
                hit_slot = SLOT_BITS'(i);
            end
        end
    end

    always_comb
    begin
        dirty_count = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            dirty_count = dirty_count + FILL_BITS'(valid_reg[i] & dirty_reg[i]);
        end
    end

    assign full       = (fill_reg == FILL_BITS'(ENTRIES));
    assign alloc_slot = full ? oldest_reg
                             : ring_wrap(SUM_BITS'(oldest_reg) + SUM_BITS'(fill_reg));
    assign scan_slot  = ring_wrap(SUM_BITS'(oldest_reg) + SUM_BITS'(idx_reg));
    assign access_wb  = full & valid_reg[alloc_slot] & dirty_reg[alloc_slot];
    assign wr_entry   = cmd.access_go & ~hit_any;
    assign load_out   = cmd.access_go | cmd.flush_emit;

    assign stat.out_free  = ~out_valid_reg | out_ready;
    assign stat.scan_done = (idx_reg == fill_reg);
    assign stat.cur_dirty = valid_reg[scan_slot] & dirty_reg[scan_slot];

    always_comb
    begin
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        oldest_next    = oldest_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        if (cmd.capture)
        begin
            idx_next    = '0;
            remain_next = dirty_count;
        end
        if (cmd.access_go)
        begin
            if (hit_any)
            begin
                if (write_reg)
                begin
                    dirty_next[hit_slot] = 1'b1;
                end
            end
            else
            begin
                valid_next[alloc_slot] = 1'b1;
                dirty_next[alloc_slot] = write_reg;
                if (full)
                begin
                    oldest_next = ring_wrap(SUM_BITS'(oldest_reg) + SUM_BITS'(1));
                end
                else
                begin
                    fill_next = fill_reg + FILL_BITS'(1);
                end
            end
        end
        if (cmd.flush_step)
        begin
            idx_next = idx_reg + FILL_BITS'(1);
        end
        if (cmd.flush_emit)
        begin
            remain_next = remain_reg - FILL_BITS'(1);
        end
        if (cmd.flush_clear)
        begin
            valid_next  = '0;
            dirty_next  = '0;
            oldest_next = '0;
            fill_next   = '0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            oldest_reg    <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            oldest_reg    <= oldest_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg   <= in_block_key;
            write_reg <= (in_command == CMD_WRITE);
        end
        if (wr_entry)
        begin
            entry_key_reg[alloc_slot] <= key_reg;
        end
        if (cmd.access_go)
        begin
            out_hit              <= hit_any;
            out_slot             <= hit_any ? hit_slot : alloc_slot;
            out_fill_needed      <= ~hit_any & ~write_reg;
            out_writeback_needed <= ~hit_any & access_wb;
            out_writeback_key    <= (~hit_any & access_wb) ? entry_key_reg[alloc_slot] : '0;
            out_last             <= 1'b1;
        end
        else if (cmd.flush_emit)
        begin
            out_hit              <= 1'b0;
            out_slot             <= scan_slot;
            out_fill_needed      <= 1'b0;
            out_writeback_needed <= 1'b1;
            out_writeback_key    <= entry_key_reg[scan_slot];
            out_last             <= (remain_reg == FILL_BITS'(1));
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/fbcc_checker.sv
// port-level checks of the fifo block cache controller, bound to the top level
// depends on fbcc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module fbcc_checker import fbcc_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic [CMD_BITS-1:0]  req_command,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic                 rsp_hit,
    input wire logic                 rsp_fill_needed,
    input wire logic                 rsp_writeback_needed,
    input wire logic [KEY_BITS-1:0]  rsp_writeback_key,
    input wire logic                 rsp_last
);

    `FBCC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_writeback_key) && $stable(rsp_last))

    `FBCC_ASSERT_NOW(a_hit_clean, clk, rst_n, rsp_valid && rsp_hit,
        !rsp_fill_needed && !rsp_writeback_needed && rsp_last)

    `FBCC_ASSERT_NOW(a_wb_key_zero, clk, rst_n, rsp_valid && !rsp_writeback_needed,
        rsp_writeback_key == '0)

    `FBCC_ASSERT_NEXT(a_access_busy, clk, rst_n,
        req_valid && req_ready && (req_command == CMD_READ || req_command == CMD_WRITE),
        !req_ready)

endmodule

bind fifo_block_cache_controller fbcc_checker u_fbcc_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .req_command          (req.command),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_hit              (rsp.hit),
    .rsp_fill_needed      (rsp.fill_needed),
    .rsp_writeback_needed (rsp.writeback_needed),
    .rsp_writeback_key    (rsp.writeback_key),
    .rsp_last             (rsp.last)
);

`default_nettype wire

FILE: bench/tb.sv
// testbench for fifo_block_cache_controller: random and directed cache requests,
// results checked against a shadow copy of the tags, valid/dirty bits and fifo order
// depends on fbcc_pkg, fbcc_if and the rtl of the controller
`timescale 1ns / 1ps

module tb;
    import fbcc_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ACCESSES = 200;
    localparam int POOL_SIZE = 6;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [CMD_BITS-1:0] command;
        logic [KEY_BITS-1:0] block_key;
    } cache_request_t;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
        logic                 fill_needed;
        logic                 writeback_needed;
        logic [KEY_BITS-1:0]  writeback_key;
        logic                 last;
    } cache_outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    fbcc_req_if req_ch ();
    fbcc_rsp_if rsp_ch ();

    fifo_block_cache_controller dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    cache_request_t queued_accesses[$];
    cache_outcome_t predicted_outcomes[$];

    logic [KEY_BITS-1:0] shadow_key[ENTRIES];
    logic                shadow_valid[ENTRIES];
    logic                shadow_dirty[ENTRIES];
    int                  shadow_oldest = 0;
    int                  shadow_count = 0;

    int accesses_sent = 0;
    int outcome_errors = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;
    int sender_idle_pct[3] = '{24, 84, 0};
    int receiver_idle_pct[3] = '{84, 24, 0};

    cache_request_t sent_access;
    cache_outcome_t seen_outcome;
    cache_outcome_t want_outcome;

    function automatic int stall_phase();
        return (accesses_sent < 90) ? 0 : (accesses_sent < 170) ? 1 : 2;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // updates the shadow cache and queues the results one request causes
    function automatic void predict_outcomes(input cache_request_t rq);
        cache_outcome_t r;
        int hit_slot;
        int victim;
        int dirty_total;
        int emitted;
        int pos;
        r = '0;
        case (rq.command)
            CMD_READ, CMD_WRITE:
            begin
                hit_slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (hit_slot < 0 && shadow_valid[i] && shadow_key[i] == rq.block_key)
                        hit_slot = i;
                end
                if (hit_slot >= 0)
                begin
                    if (rq.command == CMD_WRITE)
                        shadow_dirty[hit_slot] = 1'b1;
                    r.hit = 1'b1;
                    r.slot = SLOT_BITS'(hit_slot);
                end
                else
                begin
                    if (shadow_count < ENTRIES)
                    begin
                        victim = (shadow_oldest + shadow_count) % ENTRIES;
                        shadow_count++;
                    end
                    else
                    begin
                        victim = shadow_oldest;
                        if (shadow_valid[victim] && shadow_dirty[victim])
                        begin
                            r.writeback_needed = 1'b1;
                            r.writeback_key = shadow_key[victim];
                        end
                        shadow_oldest = (victim + 1) % ENTRIES;
                    end
                    shadow_key[victim] = rq.block_key;
                    shadow_valid[victim] = 1'b1;
                    shadow_dirty[victim] = (rq.command == CMD_WRITE);
                    r.slot = SLOT_BITS'(victim);
                    r.fill_needed = (rq.command == CMD_READ);
                end
                r.last = 1'b1;
                predicted_outcomes.push_back(r);
            end
            CMD_FLUSH:
            begin
                dirty_total = 0;
                emitted = 0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_valid[i] && shadow_dirty[i])
                        dirty_total++;
                end
                for (int i = 0; i < shadow_count; i++)
                begin
                    pos = (shadow_oldest + i) % ENTRIES;
                    if (shadow_valid[pos] && shadow_dirty[pos])
                    begin
                        emitted++;
                        r = '0;
                        r.slot = SLOT_BITS'(pos);
                        r.writeback_needed = 1'b1;
                        r.writeback_key = shadow_key[pos];
                        r.last = (emitted == dirty_total);
                        predicted_outcomes.push_back(r);
                    end
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    shadow_valid[i] = 1'b0;
                    shadow_dirty[i] = 1'b0;
                end
                shadow_oldest = 0;
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic queue_access(input logic [CMD_BITS-1:0] cmd,
                                input logic [KEY_BITS-1:0] key);
        cache_request_t rq;
        rq.command = cmd;
        rq.block_key = key;
        queued_accesses.push_back(rq);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.command <= CMD_READ;
            req_ch.block_key <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                sent_access.command = req_ch.command;
                sent_access.block_key = req_ch.block_key;
                predict_outcomes(sent_access);
                accesses_sent++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (queued_accesses.size() != 0 && !roll(sender_idle_pct[stall_phase()]))
                begin
                    sent_access = queued_accesses.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.command <= sent_access.command;
                    req_ch.block_key <= sent_access.block_key;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_outcome.hit = rsp_ch.hit;
                seen_outcome.slot = rsp_ch.slot;
                seen_outcome.fill_needed = rsp_ch.fill_needed;
                seen_outcome.writeback_needed = rsp_ch.writeback_needed;
                seen_outcome.writeback_key = rsp_ch.writeback_key;
                seen_outcome.last = rsp_ch.last;
                if (predicted_outcomes.size() == 0)
                begin
                    outcome_errors++;
                    $display(
                        "%0t: unexpected result hit=%0b slot=%0d fill=%0b wb=%0b key=%h last=%0b",
                        $time, seen_outcome.hit, seen_outcome.slot,
                        seen_outcome.fill_needed, seen_outcome.writeback_needed,
                        seen_outcome.writeback_key, seen_outcome.last);
                end
                else
                begin
                    want_outcome = predicted_outcomes.pop_front();
                    if (seen_outcome !== want_outcome)
                    begin
                        outcome_errors++;
                        $display(
                            "%0t: mismatch expected hit=%0b slot=%0d fill=%0b wb=%0b key=%h last=%0b",
                            $time, want_outcome.hit, want_outcome.slot,
                            want_outcome.fill_needed, want_outcome.writeback_needed,
                            want_outcome.writeback_key, want_outcome.last);
                        $display(
                            "%0t:          actual hit=%0b slot=%0d fill=%0b wb=%0b key=%h last=%0b",
                            $time, seen_outcome.hit, seen_outcome.slot,
                            seen_outcome.fill_needed, seen_outcome.writeback_needed,
                            seen_outcome.writeback_key, seen_outcome.last);
                    end
                end
            end
            if (!hold_used && stall_phase() == 2)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= !roll(receiver_idle_pct[stall_phase()]);
            end
        end
    end

    initial
    begin : stimulus
        logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
        logic [KEY_BITS-1:0] pick;
        logic [CMD_BITS-1:0] cmd;
        int draw;
        int random_count;
        int request_total;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_READ;
        req_ch.block_key = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            shadow_key[i] = '0;
        end

        // fill, hits, dirty marking, evictions of dirty victims on both paths
        queue_access(CMD_READ, 20'h00000);
        queue_access(CMD_WRITE, 20'hFFFFF);
        queue_access(CMD_READ, 20'h00000);
        queue_access(CMD_WRITE, 20'h00000);
        queue_access(CMD_READ, 20'hFFFFF);
        queue_access(CMD_WRITE, 20'h55555);
        queue_access(CMD_READ, 20'hAAAAA);
        queue_access(CMD_READ, 20'h12345);
        queue_access(CMD_WRITE, 20'h0F0F0);
        queue_access(CMD_FLUSH, 20'h00000);
        // flush of an empty cache and an unused code: no result
        queue_access(CMD_FLUSH, 20'hFFFFF);
        queue_access(CMD_UNUSED, 20'hFFFFF);
        // clean victims only, then a flush with nothing dirty
        queue_access(CMD_READ, 20'h00001);
        queue_access(CMD_READ, 20'h00002);
        queue_access(CMD_READ, 20'h00003);
        queue_access(CMD_READ, 20'h00004);
        queue_access(CMD_READ, 20'h00005);
        queue_access(CMD_FLUSH, 20'h00000);
        // full dirty cache flush
        queue_access(CMD_WRITE, 20'h80000);
        queue_access(CMD_WRITE, 20'h00001);
        queue_access(CMD_WRITE, 20'h7FFFF);
        queue_access(CMD_WRITE, 20'hFFFFE);
        queue_access(CMD_FLUSH, 20'h00000);

        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_BITS'($urandom);
        random_count = 0;
        while (random_count < RANDOM_ACCESSES)
        begin
            if (roll(10))
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = KEY_BITS'($urandom);
            pick = roll(85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : KEY_BITS'($urandom);
            draw = $urandom_range(0, 99);
            if (draw < 3)
                cmd = CMD_UNUSED;
            else if (draw < 10)
                cmd = CMD_FLUSH;
            else if (draw < 55)
                cmd = CMD_READ;
            else
                cmd = CMD_WRITE;
            queue_access(cmd, pick);
            if (cmd != CMD_UNUSED)
                random_count++;
        end
        request_total = queued_accesses.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accesses_sent < request_total)
            @(posedge clk);
        while (predicted_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (outcome_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: fifo_block_cache_controller.f
+incdir+src
src/fbcc_pkg.sv
src/fbcc_if.sv
src/fbcc_ctrl.sv
src/fbcc_dp.sv
src/fifo_block_cache_controller.sv
src/fbcc_checker.sv
bench/tb.sv
